// ===== rtl/linear_resampler_with_peak_agc_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the linear resampler with peak AGC
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINEAR_RESAMPLER_WITH_PEAK_AGC_TOP_ASSERT_SVH
`define LINEAR_RESAMPLER_WITH_PEAK_AGC_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LRPA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrpa assertion failed");
`define LRPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrpa assertion failed");
`else
`define LRPA_ASSERT_IMPLY(lbl, ante, cons)
`define LRPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/lrpa_pkg.sv =====
// ----------------------------------------------------------------------------
// lrpa_pkg
// Types and constants shared by the resampler/AGC controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lrpa_pkg;

  localparam int SMP_W     = 16;
  localparam int RES_W     = 12;  // phase residual
  localparam int WT_W      = 13;  // interpolation weight, up to OUT_BLOCK
  localparam int PROD_W    = 30;  // sample times weight
  localparam int WIN_W     = 20;
  localparam int GAIN_W    = 24;
  localparam int PEAK_W    = 17;
  localparam int DVD_W     = 40;  // divider dividend / quotient
  localparam int DVS_W     = 17;  // divider divisor / remainder
  localparam int SQ_W      = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_AGC_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_NUM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FLOOR = 2'd2;

  localparam logic [WIN_W-1:0]  AGC_WINDOW_RST = 20'd96000;
  localparam logic [GAIN_W-1:0] GAIN_NUM_RST   = 24'd154202;
  localparam logic [GAIN_W-1:0] GAIN_FLOOR_RST = 24'd3277;
  localparam logic [GAIN_W-1:0] GAIN_AVG_RST   = 24'd65536;
  localparam logic [GAIN_W-1:0] GAIN_MAX       = 24'hFFFFFF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_DIVI, ST_WAITI, ST_DIVQ, ST_WAITQ, ST_SQR, ST_SQRT,
    ST_WAITS, ST_PEAK, ST_CHECK, ST_GDIV, ST_WAITG, ST_AVG, ST_WAITA, ST_EMIT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_DIVI, OP_DIVQ, OP_SQR, OP_SQRT, OP_PEAK,
    OP_CHECK, OP_GDIV, OP_AVG, OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {DSEL_I, DSEL_Q, DSEL_G, DSEL_A} div_sel_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic emit;
    logic div_done;
    logic sqrt_done;
    logic hit;
    logic peak_zero;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/lrpa_div.sv =====
// ----------------------------------------------------------------------------
// lrpa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_resampler_with_peak_agc_top_assert.svh"
module lrpa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lrpa_pkg::DVD_W-1:0]  dvd,
  input  logic [lrpa_pkg::DVS_W-1:0]  dvs,
  output logic                        done,
  output logic [lrpa_pkg::DVD_W-1:0]  quo
);

  logic                       busy_r;
  logic                       done_r;
  logic [5:0]                 cnt_r;
  logic [lrpa_pkg::DVS_W-1:0] dvs_r;
  logic [lrpa_pkg::DVS_W-1:0] rem_r;
  logic [lrpa_pkg::DVD_W-1:0] quo_r;
  logic [lrpa_pkg::DVS_W:0]   rem_sh;
  logic                       fits;

  assign rem_sh = {rem_r, quo_r[lrpa_pkg::DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'd0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= 6'(lrpa_pkg::DVD_W - 1);
      dvs_r <= dvs;
      rem_r <= '0;
      quo_r <= dvd;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      rem_r <= fits ? lrpa_pkg::DVS_W'(rem_sh - {1'b0, dvs_r})
                    : rem_sh[lrpa_pkg::DVS_W-1:0];
      quo_r <= {quo_r[lrpa_pkg::DVD_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  `LRPA_ASSERT_IMPLY(a_div_no_restart, start, !busy_r)

endmodule

// ===== rtl/lrpa_sqrt.sv =====
// ----------------------------------------------------------------------------
// lrpa_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_resampler_with_peak_agc_top_assert.svh"
module lrpa_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lrpa_pkg::SQ_W-1:0]   value,
  output logic                        done,
  output logic [lrpa_pkg::PEAK_W-1:0] root
);

  logic                      busy_r;
  logic                      done_r;
  logic [lrpa_pkg::SQ_W-1:0] v_r;
  logic [lrpa_pkg::SQ_W-1:0] res_r;
  logic [lrpa_pkg::SQ_W-1:0] bit_r;
  logic [lrpa_pkg::SQ_W-1:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && bit_r[0];
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= value;
      res_r <= '0;
      bit_r <= lrpa_pkg::SQ_W'(1) << (lrpa_pkg::SQ_W - 2);
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[lrpa_pkg::PEAK_W-1:0];

  `LRPA_ASSERT_IMPLY(a_sqrt_no_restart, start, !busy_r)

endmodule

// ===== rtl/lrpa_dp.sv =====
// ----------------------------------------------------------------------------
// lrpa_dp
// Datapath: sample history, interpolation, magnitude, peak and gain, output reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_resampler_with_peak_agc_top_assert.svh"
module lrpa_dp #(
  parameter int IN_BLOCK  = 2048,
  parameter int OUT_BLOCK = 1920
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lrpa_pkg::dp_cmd_t               cmd,
  output lrpa_pkg::dp_stat_t              stat,
  input  logic [31:0]                     in_tdata,
  input  logic                            cfg_valid,
  input  logic [lrpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrpa_pkg::GAIN_W-1:0]     cfg_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [55:0]                     out_tdata,
  output logic                            out_tuser
);

  localparam logic [lrpa_pkg::WT_W-1:0]  OUT_WT     = lrpa_pkg::WT_W'(OUT_BLOCK);
  localparam logic [lrpa_pkg::WT_W-1:0]  IN_WT      = lrpa_pkg::WT_W'(IN_BLOCK);
  localparam logic [lrpa_pkg::RES_W-1:0] OUT_RES    = lrpa_pkg::RES_W'(OUT_BLOCK);
  localparam logic signed [13:0]         RES_STEP   = 14'(IN_BLOCK - OUT_BLOCK);
  // bias keeps the interpolation dividend positive: 2*OUT_BLOCK*32768 + OUT_BLOCK
  localparam logic [31:0]                INTERP_OFS = 32'(OUT_BLOCK) * 32'd65537;
  // interpolation dividend stays below 2^30; a rounded-up reciprocal with
  // 30 + clog2(divisor) fraction bits gives the exact floor over that range
  localparam int                         INTERP_D   = 2 * OUT_BLOCK;
  localparam int                         INTERP_SH  = 30 + $clog2(INTERP_D);
  localparam logic [31:0]                INTERP_RCP =
    32'(((64'd1 << INTERP_SH) + 64'(INTERP_D) - 64'd1) / 64'(INTERP_D));
  // smoothing dividend stays below 2^31; ceil(2^38 / 100)
  localparam int                         AVG_SH     = 38;
  localparam logic [31:0]                AVG_RCP    = 32'd2748779070;

  logic [lrpa_pkg::WIN_W-1:0]   agc_win_r;
  logic [lrpa_pkg::GAIN_W-1:0]  gnum_r;
  logic [lrpa_pkg::GAIN_W-1:0]  gfloor_r;

  logic signed [15:0]           prev_i_r, prev_q_r, cur_i_r, cur_q_r, oi_r, oq_r;
  logic signed [15:0]           in_i, in_q;
  logic                         have_prev_r;
  logic [lrpa_pkg::RES_W-1:0]   res_r;
  logic [lrpa_pkg::WT_W-1:0]    w0;
  logic signed [lrpa_pkg::PROD_W-1:0] p0i_r, p1i_r, p0q_r, p1q_r;
  logic [30:0]                  sqi_r, sqq_r;
  logic signed [31:0]           sqi_full, sqq_full;
  logic [lrpa_pkg::PEAK_W-1:0]  peak_r;
  logic [lrpa_pkg::WIN_W-1:0]   cnt_r, cnt_inc;
  logic                         hit_r;
  logic [lrpa_pkg::GAIN_W-1:0]  raw_r, raw_fl, gavg_r;
  logic                         gvalid_r;
  lrpa_pkg::div_sel_t           div_sel_r;
  logic                         out_valid_r;
  logic [55:0]                  out_data_r;
  logic                         out_gv_r;

  logic signed [31:0]           num_i, num_q;
  logic [31:0]                  dvd_i, dvd_q, dvd_a;
  logic signed [13:0]           res_emit;

  logic                         div_start, div_done, gdiv_done;
  logic [lrpa_pkg::DVD_W-1:0]   div_dvd, div_quo;
  logic [lrpa_pkg::DVS_W-1:0]   div_dvs;
  logic                         rcp_start, rcp_v1_r, rcp_v2_r;
  logic [31:0]                  rcp_x, rcp_m, rcp_x_r, rcp_m_r;
  logic [63:0]                  rcp_prod_r;
  logic                         sqrt_start, sqrt_done;
  logic [lrpa_pkg::SQ_W-1:0]    sqrt_val;
  logic [lrpa_pkg::PEAK_W-1:0]  mag;
  logic                         out_free;

  assign in_i     = in_tdata[15:0];
  assign in_q     = in_tdata[31:16];
  assign w0       = OUT_WT - {1'b0, res_r};
  assign num_i    = 32'(p0i_r) + 32'(p1i_r);
  assign num_q    = 32'(p0q_r) + 32'(p1q_r);
  assign dvd_i    = {num_i[30:0], 1'b0} + INTERP_OFS;
  assign dvd_q    = {num_q[30:0], 1'b0} + INTERP_OFS;
  assign raw_fl   = (raw_r < gfloor_r) ? gfloor_r : raw_r;
  assign dvd_a    = 32'(gavg_r) * 32'd99 + 32'(raw_fl) + 32'd50;
  assign sqi_full = 32'(oi_r) * 32'(oi_r);
  assign sqq_full = 32'(oq_r) * 32'(oq_r);
  assign cnt_inc  = cnt_r + lrpa_pkg::WIN_W'(1);
  assign res_emit = $signed({2'b00, res_r}) + RES_STEP;
  assign sqrt_val = {1'b0, sqi_r} + {1'b0, sqq_r};
  assign out_free = !out_valid_r || out_tready;

  // divisions by a constant: latch dividend, multiply by reciprocal, done
  always_comb begin
    rcp_start = 1'b0;
    rcp_x     = dvd_i;
    rcp_m     = INTERP_RCP;
    case (cmd.op)
      lrpa_pkg::OP_DIVI: begin
        rcp_start = 1'b1;
      end
      lrpa_pkg::OP_DIVQ: begin
        rcp_start = 1'b1;
        rcp_x     = dvd_q;
      end
      lrpa_pkg::OP_AVG: begin
        rcp_start = 1'b1;
        rcp_x     = dvd_a;
        rcp_m     = AVG_RCP;
      end
      default: ;
    endcase
  end

  // gain division by the peak
  assign div_start  = (cmd.op == lrpa_pkg::OP_GDIV);
  assign div_dvd    = lrpa_pkg::DVD_W'({gnum_r, 15'd0});
  assign div_dvs    = peak_r;
  assign div_done   = gdiv_done || rcp_v2_r;

  assign sqrt_start = (cmd.op == lrpa_pkg::OP_SQRT);

  lrpa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .done  (gdiv_done),
    .quo   (div_quo)
  );

  lrpa_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value (sqrt_val),
    .done  (sqrt_done),
    .root  (mag)
  );

  // control and configuration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agc_win_r   <= lrpa_pkg::AGC_WINDOW_RST;
      gnum_r      <= lrpa_pkg::GAIN_NUM_RST;
      gfloor_r    <= lrpa_pkg::GAIN_FLOOR_RST;
      have_prev_r <= 1'b0;
      res_r       <= '0;
      peak_r      <= '0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      gavg_r      <= lrpa_pkg::GAIN_AVG_RST;
      gvalid_r    <= 1'b0;
      div_sel_r   <= lrpa_pkg::DSEL_I;
      out_valid_r <= 1'b0;
      rcp_v1_r    <= 1'b0;
      rcp_v2_r    <= 1'b0;
    end else begin
      rcp_v1_r <= rcp_start;
      rcp_v2_r <= rcp_v1_r;

      if (cfg_valid) begin
        case (cfg_index)
          lrpa_pkg::REG_AGC_WINDOW: agc_win_r <= cfg_data[lrpa_pkg::WIN_W-1:0];
          lrpa_pkg::REG_GAIN_NUM:   gnum_r    <= cfg_data;
          lrpa_pkg::REG_GAIN_FLOOR: gfloor_r  <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.op == lrpa_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (cmd.op)
        lrpa_pkg::OP_LOAD: begin
          gvalid_r <= 1'b0;
          if (!have_prev_r) begin
            have_prev_r <= 1'b1;
            res_r       <= '0;
          end else if (res_r >= OUT_RES) begin
            res_r <= res_r - OUT_RES;
          end
        end
        lrpa_pkg::OP_DIVI: div_sel_r <= lrpa_pkg::DSEL_I;
        lrpa_pkg::OP_DIVQ: div_sel_r <= lrpa_pkg::DSEL_Q;
        lrpa_pkg::OP_GDIV: div_sel_r <= lrpa_pkg::DSEL_G;
        lrpa_pkg::OP_PEAK: begin
          if (mag > peak_r) begin
            peak_r <= mag;
          end
          cnt_r <= cnt_inc;
          hit_r <= cnt_inc >= agc_win_r;
        end
        lrpa_pkg::OP_AVG: begin
          div_sel_r <= lrpa_pkg::DSEL_A;
          peak_r    <= '0;
          cnt_r     <= '0;
        end
        lrpa_pkg::OP_EMIT: begin
          res_r <= res_emit[13] ? '0 : res_emit[lrpa_pkg::RES_W-1:0];
        end
        default: ;
      endcase

      if (div_done && div_sel_r == lrpa_pkg::DSEL_A) begin
        gavg_r   <= rcp_prod_r[AVG_SH +: lrpa_pkg::GAIN_W];
        gvalid_r <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      lrpa_pkg::OP_LOAD: begin
        if (!have_prev_r || res_r >= OUT_RES) begin
          prev_i_r <= in_i;
          prev_q_r <= in_q;
        end else begin
          cur_i_r <= in_i;
          cur_q_r <= in_q;
        end
      end
      lrpa_pkg::OP_MUL: begin
        p0i_r <= prev_i_r * $signed({1'b0, w0});
        p1i_r <= cur_i_r * $signed({1'b0, res_r});
        p0q_r <= prev_q_r * $signed({1'b0, w0});
        p1q_r <= cur_q_r * $signed({1'b0, res_r});
      end
      lrpa_pkg::OP_SQR: begin
        sqi_r <= sqi_full[30:0];
        sqq_r <= sqq_full[30:0];
      end
      lrpa_pkg::OP_CHECK: raw_r <= gavg_r;
      lrpa_pkg::OP_EMIT: begin
        prev_i_r   <= cur_i_r;
        prev_q_r   <= cur_q_r;
        out_data_r <= {gavg_r, oq_r, oi_r};
        out_gv_r   <= gvalid_r;
      end
      default: ;
    endcase

    if (rcp_start) begin
      rcp_x_r <= rcp_x;
      rcp_m_r <= rcp_m;
    end
    if (rcp_v1_r) begin
      rcp_prod_r <= 64'(rcp_x_r) * 64'(rcp_m_r);
    end

    if (div_done) begin
      case (div_sel_r)
        // quotient is the result biased by 32768
        lrpa_pkg::DSEL_I: oi_r <= {~rcp_prod_r[INTERP_SH + 15], rcp_prod_r[INTERP_SH +: 15]};
        lrpa_pkg::DSEL_Q: oq_r <= {~rcp_prod_r[INTERP_SH + 15], rcp_prod_r[INTERP_SH +: 15]};
        lrpa_pkg::DSEL_G: raw_r <= (div_quo > lrpa_pkg::DVD_W'(lrpa_pkg::GAIN_MAX))
                                   ? lrpa_pkg::GAIN_MAX : div_quo[lrpa_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign stat.have_prev = have_prev_r;
  assign stat.emit      = res_r < OUT_RES;
  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.hit       = hit_r;
  assign stat.peak_zero = (peak_r == '0);
  assign stat.out_free  = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_gv_r;

  `LRPA_ASSERT_IMPLY(a_res_bound, have_prev_r, {1'b0, res_r} < IN_WT)
  `LRPA_ASSERT_IMPLY(a_emit_slot_free, cmd.op == lrpa_pkg::OP_EMIT, out_free)

endmodule

// ===== rtl/lrpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrpa_ctrl
// Sequencer for one sample: interpolate, magnitude, peak, gain update, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_resampler_with_peak_agc_top_assert.svh"
module lrpa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  lrpa_pkg::dp_stat_t   stat,
  output lrpa_pkg::dp_cmd_t    cmd
);

  lrpa_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrpa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrpa_pkg::ST_IDLE: begin
        if (in_tvalid && stat.have_prev && stat.emit) begin
          state_nxt = lrpa_pkg::ST_MUL;
        end
      end
      lrpa_pkg::ST_MUL:   state_nxt = lrpa_pkg::ST_DIVI;
      lrpa_pkg::ST_DIVI:  state_nxt = lrpa_pkg::ST_WAITI;
      lrpa_pkg::ST_WAITI: if (stat.div_done) state_nxt = lrpa_pkg::ST_DIVQ;
      lrpa_pkg::ST_DIVQ:  state_nxt = lrpa_pkg::ST_WAITQ;
      lrpa_pkg::ST_WAITQ: if (stat.div_done) state_nxt = lrpa_pkg::ST_SQR;
      lrpa_pkg::ST_SQR:   state_nxt = lrpa_pkg::ST_SQRT;
      lrpa_pkg::ST_SQRT:  state_nxt = lrpa_pkg::ST_WAITS;
      lrpa_pkg::ST_WAITS: if (stat.sqrt_done) state_nxt = lrpa_pkg::ST_PEAK;
      lrpa_pkg::ST_PEAK:  state_nxt = lrpa_pkg::ST_CHECK;
      lrpa_pkg::ST_CHECK: begin
        if (!stat.hit) begin
          state_nxt = lrpa_pkg::ST_EMIT;
        end else if (stat.peak_zero) begin
          state_nxt = lrpa_pkg::ST_AVG;
        end else begin
          state_nxt = lrpa_pkg::ST_GDIV;
        end
      end
      lrpa_pkg::ST_GDIV:  state_nxt = lrpa_pkg::ST_WAITG;
      lrpa_pkg::ST_WAITG: if (stat.div_done) state_nxt = lrpa_pkg::ST_AVG;
      lrpa_pkg::ST_AVG:   state_nxt = lrpa_pkg::ST_WAITA;
      lrpa_pkg::ST_WAITA: if (stat.div_done) state_nxt = lrpa_pkg::ST_EMIT;
      lrpa_pkg::ST_EMIT:  if (stat.out_free) state_nxt = lrpa_pkg::ST_IDLE;
      default:            state_nxt = lrpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd.op    = lrpa_pkg::OP_NONE;
    case (state_r)
      lrpa_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = lrpa_pkg::OP_LOAD;
        end
      end
      lrpa_pkg::ST_MUL:   cmd.op = lrpa_pkg::OP_MUL;
      lrpa_pkg::ST_DIVI:  cmd.op = lrpa_pkg::OP_DIVI;
      lrpa_pkg::ST_DIVQ:  cmd.op = lrpa_pkg::OP_DIVQ;
      lrpa_pkg::ST_SQR:   cmd.op = lrpa_pkg::OP_SQR;
      lrpa_pkg::ST_SQRT:  cmd.op = lrpa_pkg::OP_SQRT;
      lrpa_pkg::ST_PEAK:  cmd.op = lrpa_pkg::OP_PEAK;
      lrpa_pkg::ST_CHECK: cmd.op = lrpa_pkg::OP_CHECK;
      lrpa_pkg::ST_GDIV:  cmd.op = lrpa_pkg::OP_GDIV;
      lrpa_pkg::ST_AVG:   cmd.op = lrpa_pkg::OP_AVG;
      lrpa_pkg::ST_EMIT:  if (stat.out_free) cmd.op = lrpa_pkg::OP_EMIT;
      default: ;
    endcase
  end

  `LRPA_ASSERT_NEXT(a_emit_to_idle, (state_r == lrpa_pkg::ST_EMIT) && stat.out_free, state_r == lrpa_pkg::ST_IDLE)

endmodule

// ===== rtl/linear_resampler_with_peak_agc_top.sv =====
// ----------------------------------------------------------------------------
// linear_resampler_with_peak_agc_top
// Linear-interpolation fractional resampler with peak-driven smoothed AGC.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    in_tdata  {in_q, in_i}
//  out_     out  out_tvalid/out_tready  out_tdata {audio_gain, out_q, out_i},
//                                       out_tuser gain_valid
//  cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// An input that yields no output is taken without leaving the idle state. One
// that yields an output holds the block for two reciprocal multiplies for the
// interpolation, a square root of 16 steps, then peak and emit. A gain update
// adds a 40-step bit-serial division by the peak and a reciprocal multiply for
// the smoothing, only the reciprocal multiply when the peak is zero.
// A finished output sits in the output register while the next input is taken;
// it only stalls the block when the next output is ready before it is taken.
// rst_n is synchronous.
`timescale 1ns / 1ps
module linear_resampler_with_peak_agc_top #(
  parameter int IN_BLOCK  = 2048,
  parameter int OUT_BLOCK = 1920
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [15:0] in_i, [31:16] in_q
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [15:0] out_i, [31:16] out_q, [55:32] audio_gain
  output logic        out_tuser,   // [0] gain_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  lrpa_pkg::dp_cmd_t  cmd;
  lrpa_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  lrpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lrpa_dp #(
    .IN_BLOCK  (IN_BLOCK),
    .OUT_BLOCK (OUT_BLOCK)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear resampler with peak AGC: a queue-fed
// driver, a scoreboard predictor of interpolation and gain smoothing, and a
// monitor that compares every output transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;

  localparam int IN_BLK  = 2048;
  localparam int OUT_BLK = 1920;
  localparam int SETTLE  = 400;

  typedef struct packed {
    logic signed [15:0] q;
    logic signed [15:0] i;
  } sample_t;

  typedef struct packed {
    logic [23:0]        gain;
    logic signed [15:0] q;
    logic signed [15:0] i;
    logic               gvalid;
  } resampled_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  linear_resampler_with_peak_agc_top #(.IN_BLOCK(IN_BLK), .OUT_BLOCK(OUT_BLK)) dut (.*);

  initial forever #10 clk = ~clk;

  // predictor state
  logic [19:0] win_len = lrpa_pkg::AGC_WINDOW_RST;
  logic [23:0] gain_num = lrpa_pkg::GAIN_NUM_RST;
  logic [23:0] gain_flr = lrpa_pkg::GAIN_FLOOR_RST;
  logic signed [15:0] last_i, last_q;
  bit          primed;
  int          residual;
  logic [16:0] peak = '0;
  logic [19:0] win_cnt = '0;
  logic [23:0] gain_avg = lrpa_pkg::GAIN_AVG_RST;

  sample_t    pending_samples[$];
  resampled_t expected_out[$];
  int  send_idle_pct = 0, recv_idle_pct = 0;
  int  hold_cycles = 0;
  bit  failed = 0;

  function automatic logic signed [15:0] lerp(int a, int b, int r);
    longint n;
    longint x;
    longint d;
    n = longint'(a) * (OUT_BLK - r) + longint'(b) * r;
    x = 2 * n + OUT_BLK;
    d = 2 * OUT_BLK;
    return 16'((x >= 0) ? x / d : -((-x + d - 1) / d));
  endfunction

  function automatic int unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    r = 0;
    for (int b = 16; b >= 0; b--)
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r |= 64'd1 << b;
    return 32'(r);
  endfunction

  task automatic predict_sample(sample_t s);
    resampled_t o;
    longint unsigned raw;
    int unsigned mag;
    if (!primed) begin
      last_i = s.i; last_q = s.q; primed = 1; residual = 0;
      return;
    end
    if (residual < OUT_BLK) begin
      o.i = lerp(last_i, s.i, residual);
      o.q = lerp(last_q, s.q, residual);
      mag = int_sqrt(longint'(o.i) * o.i + longint'(o.q) * o.q);
      if (mag > peak) peak = 17'(mag);
      win_cnt = win_cnt + 20'd1;
      o.gvalid = 0;
      if (win_cnt >= win_len) begin
        raw = gain_avg;
        if (peak != 0) begin
          raw = (longint'(gain_num) << 15) / peak;
          if (raw > lrpa_pkg::GAIN_MAX) raw = lrpa_pkg::GAIN_MAX;
        end
        if (raw < gain_flr) raw = gain_flr;
        gain_avg = 24'((99 * longint'(gain_avg) + raw + 50) / 100);
        peak = 0; win_cnt = 0; o.gvalid = 1;
      end
      o.gain = gain_avg;
      expected_out.push_back(o);
      residual += IN_BLK;
    end
    residual -= OUT_BLK;
    if (residual < 0) residual = 0;
    residual &= 12'hFFF;
    last_i = s.i; last_q = s.q;
  endtask

  // driver
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      predict_sample(in_tdata);
      void'(pending_samples.pop_front());
    end
    if (pending_samples.size() > 0 &&
        !($urandom_range(99) < send_idle_pct && !(in_tvalid && !in_tready))) begin
      in_tvalid <= 1;
      in_tdata  <= pending_samples[0];
    end else if (!(in_tvalid && !in_tready)) begin
      in_tvalid <= 0;
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    resampled_t got, want;
    if (out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser};
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected output %h", $time, got);
        failed = 1;
      end else begin
        want = expected_out.pop_front();
        if (got.i !== want.i || got.q !== want.q)
          $display("%0t: sample mismatch expected i=%0d q=%0d actual i=%0d q=%0d",
                   $time, want.i, want.q, got.i, got.q);
        if (got.gvalid !== want.gvalid)
          $display("%0t: gain_valid expected %b actual %b", $time, want.gvalid, got.gvalid);
        if (got.gain !== want.gain)
          $display("%0t: audio_gain expected %0d actual %0d", $time, want.gain, got.gain);
        if (got !== want) failed = 1;
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      lrpa_pkg::REG_AGC_WINDOW: win_len  = val[19:0];
      lrpa_pkg::REG_GAIN_NUM:   gain_num = val;
      lrpa_pkg::REG_GAIN_FLOOR: gain_flr = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || in_tvalid || expected_out.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic sample_t rand_sample(int amp);
    sample_t s;
    s.i = 16'($signed($urandom_range(2 * amp)) - amp);
    s.q = 16'($signed($urandom_range(2 * amp)) - amp);
    return s;
  endfunction

  task automatic queue_random(int n);
    int amp;
    for (int k = 0; k < n; k++) begin
      amp = ($urandom_range(3) == 0) ? 32767 : $urandom_range(1, 32767);
      if ($urandom_range(19) == 0) pending_samples.push_back({16'h8000, 16'h8000});
      else pending_samples.push_back(rand_sample(amp));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset registers, extremes, zero peak, long stretch of ties
    send_idle_pct = 21; recv_idle_pct = 54;
    pending_samples.push_back({16'sh7FFF, 16'sh8000});
    pending_samples.push_back({16'sh8000, 16'sh7FFF});
    pending_samples.push_back({16'sh7FFF, 16'sh7FFF});
    pending_samples.push_back({16'sh8000, 16'sh8000});
    pending_samples.push_back({16'sh0001, 16'shFFFF});
    pending_samples.push_back('0);
    drain();
    write_reg(lrpa_pkg::REG_AGC_WINDOW, 24'd1);
    write_reg(lrpa_pkg::REG_GAIN_NUM, 24'hFFFFFF);
    write_reg(lrpa_pkg::REG_GAIN_FLOOR, 24'd0);
    for (int k = 0; k < 6; k++) pending_samples.push_back('0);  // zero peak
    pending_samples.push_back({16'sh0000, 16'sh0001});          // saturating gain
    pending_samples.push_back({16'sh8000, 16'sh8000});
    for (int k = 0; k < 8; k++) pending_samples.push_back(rand_sample(32767));
    drain();

    // window of zero, high floor; receiver stalls long so input backs up
    write_reg(lrpa_pkg::REG_AGC_WINDOW, 24'd0);
    write_reg(lrpa_pkg::REG_GAIN_FLOOR, 24'hFFFFFF);
    write_reg(lrpa_pkg::REG_GAIN_NUM, 24'd0);
    hold_cycles = 3000;
    queue_random(200);
    drain();

    write_reg(lrpa_pkg::REG_AGC_WINDOW, 24'hFFFFF);
    write_reg(lrpa_pkg::REG_GAIN_NUM, lrpa_pkg::GAIN_NUM_RST);
    write_reg(lrpa_pkg::REG_GAIN_FLOOR, lrpa_pkg::GAIN_FLOOR_RST);
    send_idle_pct = 54; recv_idle_pct = 21;
    queue_random(200);
    drain();

    write_reg(lrpa_pkg::REG_AGC_WINDOW, 24'd7);
    write_reg(lrpa_pkg::REG_GAIN_NUM, 24'd154202);
    write_reg(lrpa_pkg::REG_GAIN_FLOOR, 24'd40000);
    queue_random(200);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(lrpa_pkg::REG_AGC_WINDOW, 24'd3);
    write_reg(lrpa_pkg::REG_GAIN_NUM, 24'd1);
    write_reg(lrpa_pkg::REG_GAIN_FLOOR, 24'd0);
    queue_random(200);
    drain();

    if (!failed) $display("linear_resampler_with_peak_agc_top regression: pass");
    else $display("linear_resampler_with_peak_agc_top regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("linear_resampler_with_peak_agc_top regression: fail");
    $finish;
  end
endmodule
